@@ src/twiss_parameter_transport_macros.svh @@
// Assertion macros used by the Twiss transport top level.
`ifndef TWISS_PARAMETER_TRANSPORT_MACROS_SVH
`define TWISS_PARAMETER_TRANSPORT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define TWP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define TWP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define TWP_ASSERT(lbl, clk, rstn, prop, msg)
`define TWP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ src/twp_pkg.sv @@
// Types, widths and helper functions for the Twiss transport pipeline.
`default_nettype none

package twp_pkg;

  // Number format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Internal widths, derived from the word and fraction widths
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int PART_W    = 2 * WORD_BITS + 1;
  localparam int SUM_W     = 2 * WORD_BITS + 4;
  localparam int DSUM_W    = 2 * WORD_BITS + 3;
  localparam int ACC_W     = 3 * WORD_BITS + 5;
  localparam int RND_SHIFT = 2 * FRAC_BITS;
  localparam int RES_W     = ACC_W - RND_SHIFT;

  // Array shapes
  localparam int NUM_PLANES = 2;
  localparam int NUM_ELEMS  = 4;
  localparam int NUM_PAIRS  = 10;
  localparam int NUM_OUT    = 3;
  localparam int NUM_DISP   = 2;
  localparam int NUM_DPROD  = 4;
  localparam int PAIR_W     = 4;
  localparam int OUT_W      = 2;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [PART_W-1:0]    part_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [DSUM_W-1:0]    dsum_t;
  typedef logic signed [ACC_W-1:0]     acc_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA_X_START     = 3'd0,
    CFG_BETA_Y_START     = 3'd1,
    CFG_ALPHA_X_START    = 3'd2,
    CFG_ALPHA_Y_START    = 3'd3,
    CFG_GAMMA_X_START    = 3'd4,
    CFG_GAMMA_Y_START    = 3'd5,
    CFG_DISP_X_START     = 3'd6,
    CFG_DISP_SLOPE_START = 3'd7
  } cfg_reg_e;

  // Transverse planes
  typedef enum logic {
    PL_X = 1'b0,
    PL_Y = 1'b1
  } plane_e;

  // Elements of one 2x2 block: row 0 (a, b), row 1 (c, d)
  typedef enum logic [1:0] {
    EL_A = 2'd0,
    EL_B = 2'd1,
    EL_C = 2'd2,
    EL_D = 2'd3
  } elem_e;

  // Products of two block elements
  typedef enum logic [PAIR_W-1:0] {
    PR_AA = 4'd0,
    PR_AB = 4'd1,
    PR_BB = 4'd2,
    PR_AC = 4'd3,
    PR_AD = 4'd4,
    PR_BC = 4'd5,
    PR_BD = 4'd6,
    PR_CC = 4'd7,
    PR_CD = 4'd8,
    PR_DD = 4'd9
  } pair_e;

  // Twiss functions of one plane
  typedef enum logic [OUT_W-1:0] {
    OUT_BETA  = 2'd0,
    OUT_ALPHA = 2'd1,
    OUT_GAMMA = 2'd2
  } out_e;

  // Dispersion products: row times start dispersion or start slope
  typedef enum logic [1:0] {
    DP_A_D0 = 2'd0,
    DP_B_DS = 2'd1,
    DP_C_D0 = 2'd2,
    DP_D_DS = 2'd3
  } dprod_e;

  // Dispersion rows
  typedef enum logic {
    DR_DISP  = 1'b0,
    DR_SLOPE = 1'b1
  } drow_e;

  typedef struct packed {
    word_t beta_x;
    word_t beta_y;
    word_t alpha_x;
    word_t alpha_y;
    word_t gamma_x;
    word_t gamma_y;
    word_t disp_x;
    word_t disp_slope;
  } cfg_t;

  // Load enables of the five pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  localparam word_t WordOne = word_t'(1) <<< FRAC_BITS;
  localparam word_t WordMax = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WordMin = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
  localparam acc_t  AccHalf = acc_t'(1) <<< (RND_SHIFT - 1);

  // Start value that multiplies a given element product
  function automatic out_e pair_start(pair_e p);
    out_e o;
    case (p)
      PR_AA, PR_AC, PR_CC:        o = OUT_BETA;
      PR_AB, PR_AD, PR_BC, PR_CD: o = OUT_ALPHA;
      default:                    o = OUT_GAMMA;
    endcase
    return o;
  endfunction

  // Drop the extra fraction (the rounding offset is added earlier) and clamp to a word
  function automatic word_t round_sat(acc_t acc);
    logic [RES_W-1:0] r;
    logic             all0;
    logic             all1;
    word_t            res;
    r    = acc[ACC_W-1:RND_SHIFT];
    all0 = ~|r[RES_W-1:WORD_BITS-1];
    all1 = &r[RES_W-1:WORD_BITS-1];
    if (!acc[ACC_W-1]) begin
      res = all0 ? word_t'(r[WORD_BITS-1:0]) : WordMax;
    end else begin
      res = all1 ? word_t'(r[WORD_BITS-1:0]) : WordMin;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/twp_if.sv @@
// Request channels: transfer matrices in, Twiss results out.
`default_nettype none

interface twp_in_if import twp_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t mx_11;
  word_t mx_12;
  word_t mx_21;
  word_t mx_22;
  word_t my_33;
  word_t my_34;
  word_t my_43;
  word_t my_44;
  word_t disp_term_16;
  word_t disp_term_26;

  modport source (
    output valid, mx_11, mx_12, mx_21, mx_22, my_33, my_34, my_43, my_44,
           disp_term_16, disp_term_26,
    input  ready
  );
  modport sink (
    input  valid, mx_11, mx_12, mx_21, mx_22, my_33, my_34, my_43, my_44,
           disp_term_16, disp_term_26,
    output ready
  );
endinterface

interface twp_out_if import twp_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t beta_x;
  word_t beta_y;
  word_t alpha_x;
  word_t alpha_y;
  word_t gamma_x;
  word_t gamma_y;
  word_t disp_x;
  word_t disp_slope;

  modport source (
    output valid, beta_x, beta_y, alpha_x, alpha_y, gamma_x, gamma_y, disp_x,
           disp_slope,
    input  ready
  );
  modport sink (
    input  valid, beta_x, beta_y, alpha_x, alpha_y, gamma_x, gamma_y, disp_x,
           disp_slope,
    output ready
  );
endinterface

`default_nettype wire

@@ src/twp_prod.sv @@
// Stage 1: element-pair products of both blocks and the dispersion products.
`default_nettype none

module twp_prod import twp_pkg::*; (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  cfg_t     cfg_i,
  input  word_t    mat_i  [NUM_PLANES][NUM_ELEMS],
  input  word_t    term_i [NUM_DISP],
  output prod_t    pp_o   [NUM_PLANES][NUM_PAIRS],
  output prod_t    dp_o   [NUM_DPROD],
  output word_t    term_o [NUM_DISP]
);

  prod_t pp_q   [NUM_PLANES][NUM_PAIRS];
  prod_t dp_q   [NUM_DPROD];
  word_t term_q [NUM_DISP];

  // Multiply element pairs of each block
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int pl = 0; pl < NUM_PLANES; pl++) begin
        pp_q[pl][PR_AA] <= prod_t'(mat_i[pl][EL_A]) * prod_t'(mat_i[pl][EL_A]);
        pp_q[pl][PR_AB] <= prod_t'(mat_i[pl][EL_A]) * prod_t'(mat_i[pl][EL_B]);
        pp_q[pl][PR_BB] <= prod_t'(mat_i[pl][EL_B]) * prod_t'(mat_i[pl][EL_B]);
        pp_q[pl][PR_AC] <= prod_t'(mat_i[pl][EL_A]) * prod_t'(mat_i[pl][EL_C]);
        pp_q[pl][PR_AD] <= prod_t'(mat_i[pl][EL_A]) * prod_t'(mat_i[pl][EL_D]);
        pp_q[pl][PR_BC] <= prod_t'(mat_i[pl][EL_B]) * prod_t'(mat_i[pl][EL_C]);
        pp_q[pl][PR_BD] <= prod_t'(mat_i[pl][EL_B]) * prod_t'(mat_i[pl][EL_D]);
        pp_q[pl][PR_CC] <= prod_t'(mat_i[pl][EL_C]) * prod_t'(mat_i[pl][EL_C]);
        pp_q[pl][PR_CD] <= prod_t'(mat_i[pl][EL_C]) * prod_t'(mat_i[pl][EL_D]);
        pp_q[pl][PR_DD] <= prod_t'(mat_i[pl][EL_D]) * prod_t'(mat_i[pl][EL_D]);
      end
    end
  end

  // Multiply the horizontal rows by the start dispersion and slope; carry the terms
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      dp_q[DP_A_D0] <= prod_t'(mat_i[PL_X][EL_A]) * prod_t'(cfg_i.disp_x);
      dp_q[DP_B_DS] <= prod_t'(mat_i[PL_X][EL_B]) * prod_t'(cfg_i.disp_slope);
      dp_q[DP_C_D0] <= prod_t'(mat_i[PL_X][EL_C]) * prod_t'(cfg_i.disp_x);
      dp_q[DP_D_DS] <= prod_t'(mat_i[PL_X][EL_D]) * prod_t'(cfg_i.disp_slope);
      term_q        <= term_i;
    end
  end

  assign pp_o   = pp_q;
  assign dp_o   = dp_q;
  assign term_o = term_q;

endmodule

`default_nettype wire

@@ src/twp_part.sv @@
// Stage 2: split pair products into word halves times start values; dispersion sums.
`default_nettype none

module twp_part import twp_pkg::*; (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  cfg_t     cfg_i,
  input  prod_t    pp_i   [NUM_PLANES][NUM_PAIRS],
  input  prod_t    dp_i   [NUM_DPROD],
  input  word_t    term_i [NUM_DISP],
  output prod_t    hr_o   [NUM_PLANES][NUM_PAIRS],
  output part_t    lr_o   [NUM_PLANES][NUM_PAIRS],
  output dsum_t    ds_o   [NUM_DISP]
);

  word_t st   [NUM_PLANES][NUM_OUT];
  prod_t hr_d [NUM_PLANES][NUM_PAIRS];
  part_t lr_d [NUM_PLANES][NUM_PAIRS];
  prod_t hr_q [NUM_PLANES][NUM_PAIRS];
  part_t lr_q [NUM_PLANES][NUM_PAIRS];
  dsum_t ds_q [NUM_DISP];

  // Start values of each plane
  assign st[PL_X][OUT_BETA]  = cfg_i.beta_x;
  assign st[PL_X][OUT_ALPHA] = cfg_i.alpha_x;
  assign st[PL_X][OUT_GAMMA] = cfg_i.gamma_x;
  assign st[PL_Y][OUT_BETA]  = cfg_i.beta_y;
  assign st[PL_Y][OUT_ALPHA] = cfg_i.alpha_y;
  assign st[PL_Y][OUT_GAMMA] = cfg_i.gamma_y;

  // Upper half is signed, lower half is unsigned; each meets its start value
  always_comb begin
    for (int pl = 0; pl < NUM_PLANES; pl++) begin
      for (int pr = 0; pr < NUM_PAIRS; pr++) begin
        hr_d[pl][pr] = prod_t'(word_t'(pp_i[pl][pr][PROD_W-1:WORD_BITS]))
                     * prod_t'(st[pl][pair_start(pair_e'(PAIR_W'(pr)))]);
        lr_d[pl][pr] = part_t'(pp_i[pl][pr][WORD_BITS-1:0])
                     * part_t'(st[pl][pair_start(pair_e'(PAIR_W'(pr)))]);
      end
    end
  end

  // Register partial products and the dispersion sums
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      hr_q <= hr_d;
      lr_q <= lr_d;
      ds_q[DR_DISP]  <= dsum_t'(dp_i[DP_A_D0]) + dsum_t'(dp_i[DP_B_DS])
                      + (dsum_t'(term_i[DR_DISP]) <<< FRAC_BITS);
      ds_q[DR_SLOPE] <= dsum_t'(dp_i[DP_C_D0]) + dsum_t'(dp_i[DP_D_DS])
                      + (dsum_t'(term_i[DR_SLOPE]) <<< FRAC_BITS);
    end
  end

  assign hr_o = hr_q;
  assign lr_o = lr_q;
  assign ds_o = ds_q;

endmodule

`default_nettype wire

@@ src/twp_accum.sv @@
// Stages 3 and 4: weighted sums of partial products, then full-width accumulation.
`default_nettype none

module twp_accum import twp_pkg::*; (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  prod_t    hr_i   [NUM_PLANES][NUM_PAIRS],
  input  part_t    lr_i   [NUM_PLANES][NUM_PAIRS],
  input  dsum_t    ds_i   [NUM_DISP],
  output acc_t     acc_o  [NUM_PLANES][NUM_OUT],
  output acc_t     accd_o [NUM_DISP]
);

  sum_t  vh     [NUM_PLANES][NUM_PAIRS];
  sum_t  vl     [NUM_PLANES][NUM_PAIRS];
  sum_t  sh_q   [NUM_PLANES][NUM_OUT];
  sum_t  sl_q   [NUM_PLANES][NUM_OUT];
  dsum_t ds_q   [NUM_DISP];
  acc_t  acc_q  [NUM_PLANES][NUM_OUT];
  acc_t  accd_q [NUM_DISP];

  // Signed weights of the pair products in beta, alpha and gamma
  function automatic sum_t mix(out_e k, sum_t v [NUM_PAIRS]);
    sum_t s;
    case (k)
      OUT_BETA:  s = v[PR_AA] - (v[PR_AB] <<< 1) + v[PR_BB];
      OUT_ALPHA: s = v[PR_AD] + v[PR_BC] - v[PR_AC] - v[PR_BD];
      OUT_GAMMA: s = v[PR_CC] - (v[PR_CD] <<< 1) + v[PR_DD];
      default:   s = '0;
    endcase
    return s;
  endfunction

  // Sign-extend partial products to the sum width
  always_comb begin
    for (int pl = 0; pl < NUM_PLANES; pl++) begin
      for (int pr = 0; pr < NUM_PAIRS; pr++) begin
        vh[pl][pr] = sum_t'(hr_i[pl][pr]);
        vl[pl][pr] = sum_t'(lr_i[pl][pr]);
      end
    end
  end

  // Stage 3: sum upper and lower halves separately; hold the dispersion sums
  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      for (int pl = 0; pl < NUM_PLANES; pl++) begin
        for (int k = 0; k < NUM_OUT; k++) begin
          sh_q[pl][k] <= mix(out_e'(OUT_W'(k)), vh[pl]);
          sl_q[pl][k] <= mix(out_e'(OUT_W'(k)), vl[pl]);
        end
      end
      ds_q <= ds_i;
    end
  end

  // Stage 4: join the halves and add the rounding offset
  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      for (int pl = 0; pl < NUM_PLANES; pl++) begin
        for (int k = 0; k < NUM_OUT; k++) begin
          acc_q[pl][k] <= (acc_t'(sh_q[pl][k]) <<< WORD_BITS) + acc_t'(sl_q[pl][k])
                        + AccHalf;
        end
      end
      for (int j = 0; j < NUM_DISP; j++) begin
        accd_q[j] <= (acc_t'(ds_q[j]) <<< FRAC_BITS) + AccHalf;
      end
    end
  end

  assign acc_o  = acc_q;
  assign accd_o = accd_q;

endmodule

`default_nettype wire

@@ src/twp_round.sv @@
// Stage 5: round, saturate and hold the result word of every field.
`default_nettype none

module twp_round import twp_pkg::*; (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  acc_t     acc_i  [NUM_PLANES][NUM_OUT],
  input  acc_t     accd_i [NUM_DISP],
  output word_t    res_o  [NUM_PLANES][NUM_OUT],
  output word_t    disp_o [NUM_DISP]
);

  word_t res_q  [NUM_PLANES][NUM_OUT];
  word_t disp_q [NUM_DISP];

  // Load the output register when the result slot is free or being taken
  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      for (int pl = 0; pl < NUM_PLANES; pl++) begin
        for (int k = 0; k < NUM_OUT; k++) begin
          res_q[pl][k] <= round_sat(acc_i[pl][k]);
        end
      end
      for (int j = 0; j < NUM_DISP; j++) begin
        disp_q[j] <= round_sat(accd_i[j]);
      end
    end
  end

  assign res_o  = res_q;
  assign disp_o = disp_q;

endmodule

`default_nettype wire

@@ src/twiss_parameter_transport.sv @@
// Top level of the Twiss parameter transport pipeline.
// Throughput: one request per cycle while the output is not stalled; five register stages, the last one the output.
// A stalled output holds the pipeline in place; empty stages still fill up behind it.
// Reset clears all stage valid bits and loads the start values (beta and gamma 1.0).
`default_nettype none
`include "twiss_parameter_transport_macros.svh"

module twiss_parameter_transport import twp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  twp_in_if.sink               in_i,
  twp_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  word_t                cfg_wdata_i
);

  cfg_t       cfg_q;
  pipe_en_t   en;
  logic [4:0] vld_d;
  logic [4:0] vld_q;

  word_t mat  [NUM_PLANES][NUM_ELEMS];
  word_t term [NUM_DISP];
  prod_t pp   [NUM_PLANES][NUM_PAIRS];
  prod_t dp   [NUM_DPROD];
  word_t term1 [NUM_DISP];
  prod_t hr   [NUM_PLANES][NUM_PAIRS];
  part_t lr   [NUM_PLANES][NUM_PAIRS];
  dsum_t ds   [NUM_DISP];
  acc_t  acc  [NUM_PLANES][NUM_OUT];
  acc_t  accd [NUM_DISP];
  word_t res  [NUM_PLANES][NUM_OUT];
  word_t disp [NUM_DISP];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beta_x     <= WordOne;
      cfg_q.beta_y     <= WordOne;
      cfg_q.alpha_x    <= '0;
      cfg_q.alpha_y    <= '0;
      cfg_q.gamma_x    <= WordOne;
      cfg_q.gamma_y    <= WordOne;
      cfg_q.disp_x     <= '0;
      cfg_q.disp_slope <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_BETA_X_START:     cfg_q.beta_x     <= cfg_wdata_i;
        CFG_BETA_Y_START:     cfg_q.beta_y     <= cfg_wdata_i;
        CFG_ALPHA_X_START:    cfg_q.alpha_x    <= cfg_wdata_i;
        CFG_ALPHA_Y_START:    cfg_q.alpha_y    <= cfg_wdata_i;
        CFG_GAMMA_X_START:    cfg_q.gamma_x    <= cfg_wdata_i;
        CFG_GAMMA_Y_START:    cfg_q.gamma_y    <= cfg_wdata_i;
        CFG_DISP_X_START:     cfg_q.disp_x     <= cfg_wdata_i;
        CFG_DISP_SLOPE_START: cfg_q.disp_slope <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the next one advances
  assign en.s5 = !vld_q[4] || out_o.ready;
  assign en.s4 = !vld_q[3] || en.s5;
  assign en.s3 = !vld_q[2] || en.s4;
  assign en.s2 = !vld_q[1] || en.s3;
  assign en.s1 = !vld_q[0] || en.s2;

  assign vld_d[0] = en.s1 ? in_i.valid : vld_q[0];
  assign vld_d[1] = en.s2 ? vld_q[0]   : vld_q[1];
  assign vld_d[2] = en.s3 ? vld_q[1]   : vld_q[2];
  assign vld_d[3] = en.s4 ? vld_q[2]   : vld_q[3];
  assign vld_d[4] = en.s5 ? vld_q[3]   : vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = en.s1;
  assign out_o.valid = vld_q[4];

  // Unpack the request into per-plane blocks
  assign mat[PL_X][EL_A] = in_i.mx_11;
  assign mat[PL_X][EL_B] = in_i.mx_12;
  assign mat[PL_X][EL_C] = in_i.mx_21;
  assign mat[PL_X][EL_D] = in_i.mx_22;
  assign mat[PL_Y][EL_A] = in_i.my_33;
  assign mat[PL_Y][EL_B] = in_i.my_34;
  assign mat[PL_Y][EL_C] = in_i.my_43;
  assign mat[PL_Y][EL_D] = in_i.my_44;
  assign term[DR_DISP]   = in_i.disp_term_16;
  assign term[DR_SLOPE]  = in_i.disp_term_26;

  twp_prod u_prod (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .mat_i  (mat),
    .term_i (term),
    .pp_o   (pp),
    .dp_o   (dp),
    .term_o (term1)
  );

  twp_part u_part (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .pp_i   (pp),
    .dp_i   (dp),
    .term_i (term1),
    .hr_o   (hr),
    .lr_o   (lr),
    .ds_o   (ds)
  );

  twp_accum u_accum (
    .clk_i  (clk_i),
    .en_i   (en),
    .hr_i   (hr),
    .lr_i   (lr),
    .ds_i   (ds),
    .acc_o  (acc),
    .accd_o (accd)
  );

  twp_round u_round (
    .clk_i  (clk_i),
    .en_i   (en),
    .acc_i  (acc),
    .accd_i (accd),
    .res_o  (res),
    .disp_o (disp)
  );

  // Pack the result
  assign out_o.beta_x     = res[PL_X][OUT_BETA];
  assign out_o.beta_y     = res[PL_Y][OUT_BETA];
  assign out_o.alpha_x    = res[PL_X][OUT_ALPHA];
  assign out_o.alpha_y    = res[PL_Y][OUT_ALPHA];
  assign out_o.gamma_x    = res[PL_X][OUT_GAMMA];
  assign out_o.gamma_y    = res[PL_Y][OUT_GAMMA];
  assign out_o.disp_x     = disp[DR_DISP];
  assign out_o.disp_slope = disp[DR_SLOPE];

  // An empty output stage lets the whole pipeline flow
  `TWP_ASSERT(ap_empty_flows, clk_i, rst_ni, !vld_q[4] |-> in_i.ready, "input stalled with empty output")
  // A new result only comes from a full stage 4
  `TWP_ASSERT(ap_out_from_s4, clk_i, rst_ni, $rose(vld_q[4]) |-> $past(vld_q[3]), "result without source")
  // A stalled output keeps stage 4 full behind it
  `TWP_ASSERT_NEXT(ap_s4_hold, clk_i, rst_ni, vld_q[3] && vld_q[4] && !out_o.ready, vld_q[3] && vld_q[4], "stage 4 lost under stall")

endmodule

`default_nettype wire
